@@ hdl/tpvd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpvd_pkg: shared types and constants for the tilt pour volume detector
// Phase codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package tpvd_pkg;

  localparam int ANGLE_W = 11;
  localparam int PRES_W  = 15;
  localparam int TIME_W  = 32;
  localparam int CFG16_W = 16;
  localparam int VOL_W   = 24;
  localparam int DIFF_W  = PRES_W + 1;
  localparam int PROD_W  = DIFF_W + CFG16_W + 1;
  localparam int RND_W   = PROD_W + 1;
  localparam int VWIDE_W = RND_W - 8;
  localparam int ADDR_W  = 3;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_POURING   = 2'd1,
    PH_SETTLING  = 2'd2,
    PH_REPORTING = 2'd3
  } phase_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_TIP_LIMIT     = 3'd0,
    REG_UPRIGHT_LIMIT = 3'd1,
    REG_SETTLE_TIME   = 3'd2,
    REG_VOLUME_GAIN   = 3'd3,
    REG_MIN_VOLUME    = 3'd4
  } reg_idx_t;

  localparam logic [ANGLE_W-1:0] TIP_LIMIT_RST     = 11'd450;
  localparam logic [ANGLE_W-1:0] UPRIGHT_LIMIT_RST = 11'd200;
  localparam logic [CFG16_W-1:0] SETTLE_TIME_RST   = 16'd2000;
  localparam logic [CFG16_W-1:0] VOLUME_GAIN_RST   = 16'd2560;
  localparam logic [CFG16_W-1:0] MIN_VOLUME_RST    = 16'd160;

  // Saturation limits of the 24-bit signed volume, at the wide result width.
  localparam logic signed [VWIDE_W-1:0] VOL_MAX = 26'sd8388607;
  localparam logic signed [VWIDE_W-1:0] VOL_MIN = -26'sd8388608;

  localparam logic signed [RND_W-1:0] RND_HALF = 34'sd128;

endpackage

@@ hdl/tilt_pour_volume_detector.sv @@
// ----------------------------------------------------------------------------
// tilt_pour_volume_detector: pour detection and volume report from samples
// Idle / pouring / settling / reporting phase tracker with a pressure-drop
// volume estimate, rounded and saturated, and a minimum-volume flag.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one sensor sample per word. in_tdata bits, low to high:
//           tilt[10:0], pressure[25:11], now_ms[57:26], zero pad to 64.
//   out_* : exactly one result word per sample. out_tuser is report_valid.
//           out_tdata: phase[1:0], volume[25:2], duration_ms[57:26],
//           recorded[58], zero pad to 64.
//   cfg_* : cfg_we writes cfg_wdata to register cfg_addr (0 tip limit,
//           1 upright limit, 2 settle_time, 3 volume_gain, 4 min_volume);
//           other indexes are ignored. Write only while the block is idle.
// Timing
//   Throughput is one sample per cycle while out_tready is high. The phase
//   machine and pressure difference are registered at accept, then the
//   16x17 volume multiply, rounding and saturation fill the output register.
// Reset
//   rst_n low (synchronous) empties the pipeline, sets phase to idle,
//   clears baseline/start/time state and loads the default registers.
// Stall
//   With out_tready low the output word holds; one more sample is taken
//   into the first stage, then in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module tilt_pour_volume_detector (
  input  logic        clk,
  input  logic        rst_n,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // tilt, pressure, now_ms
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // phase, volume, duration_ms, recorded
  output logic        out_tuser,  // report_valid
  // register writes
  input  logic                         cfg_we,
  input  logic [tpvd_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [tpvd_pkg::CFG16_W-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tpvd_pkg::ANGLE_W-1:0] tip_limit_r;
  logic [tpvd_pkg::ANGLE_W-1:0] upright_limit_r;
  logic [tpvd_pkg::CFG16_W-1:0] settle_time_r;
  logic [tpvd_pkg::CFG16_W-1:0] volume_gain_r;
  logic [tpvd_pkg::CFG16_W-1:0] min_volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_limit_r     <= tpvd_pkg::TIP_LIMIT_RST;
      upright_limit_r <= tpvd_pkg::UPRIGHT_LIMIT_RST;
      settle_time_r   <= tpvd_pkg::SETTLE_TIME_RST;
      volume_gain_r   <= tpvd_pkg::VOLUME_GAIN_RST;
      min_volume_r    <= tpvd_pkg::MIN_VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpvd_pkg::REG_TIP_LIMIT:     tip_limit_r     <= cfg_wdata[tpvd_pkg::ANGLE_W-1:0];
        tpvd_pkg::REG_UPRIGHT_LIMIT: upright_limit_r <= cfg_wdata[tpvd_pkg::ANGLE_W-1:0];
        tpvd_pkg::REG_SETTLE_TIME:   settle_time_r   <= cfg_wdata;
        tpvd_pkg::REG_VOLUME_GAIN:   volume_gain_r   <= cfg_wdata;
        tpvd_pkg::REG_MIN_VOLUME:    min_volume_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input field unpack and pipeline flow control
  // --------------------------------------------------------------------------
  logic [tpvd_pkg::ANGLE_W-1:0] tilt;
  logic [tpvd_pkg::PRES_W-1:0]  pressure;
  logic [tpvd_pkg::TIME_W-1:0]  now_ms;

  assign tilt     = in_tdata[10:0];
  assign pressure = in_tdata[25:11];
  assign now_ms   = in_tdata[57:26];

  logic s1_vld_r, out_vld_r;
  logic out_adv, s1_adv, in_accept;

  assign out_adv   = !out_vld_r || out_tready;
  assign s1_adv    = !s1_vld_r || out_adv;
  assign in_tready = s1_adv;
  assign in_accept = in_tvalid && s1_adv;

  // --------------------------------------------------------------------------
  // Phase machine (advances only on an accepted sample)
  // --------------------------------------------------------------------------
  tpvd_pkg::phase_t             mode_r, mode_nxt;
  logic [tpvd_pkg::PRES_W-1:0]  baseline_r, baseline_nxt;
  logic [tpvd_pkg::PRES_W-1:0]  start_pres_r, start_pres_nxt;
  logic [tpvd_pkg::TIME_W-1:0]  pour_t0_r, pour_t0_nxt;
  logic [tpvd_pkg::TIME_W-1:0]  settle_t0_r, settle_t0_nxt;
  logic                         rep_nxt;
  logic                         upright, tipped, settled;
  logic [tpvd_pkg::TIME_W-1:0]  settle_elapsed;

  assign upright        = tilt < upright_limit_r;
  assign tipped         = tilt > tip_limit_r;
  assign settle_elapsed = now_ms - settle_t0_r;
  assign settled        = settle_elapsed >= {16'd0, settle_time_r};

  always_comb begin
    mode_nxt       = mode_r;
    baseline_nxt   = baseline_r;
    start_pres_nxt = start_pres_r;
    pour_t0_nxt    = pour_t0_r;
    settle_t0_nxt  = settle_t0_r;
    rep_nxt        = 1'b0;
    case (mode_r)
      tpvd_pkg::PH_IDLE: begin
        if (upright) baseline_nxt = pressure;
        if (tipped) begin
          // a sample that is both upright and tipped snapshots itself
          start_pres_nxt = upright ? pressure : baseline_r;
          pour_t0_nxt    = now_ms;
          mode_nxt       = tpvd_pkg::PH_POURING;
        end
      end
      tpvd_pkg::PH_POURING: begin
        if (upright) begin
          settle_t0_nxt = now_ms;
          mode_nxt      = tpvd_pkg::PH_SETTLING;
        end
      end
      tpvd_pkg::PH_SETTLING: begin
        if (tipped)       mode_nxt = tpvd_pkg::PH_POURING;
        else if (settled) mode_nxt = tpvd_pkg::PH_REPORTING;
      end
      default: begin
        // reporting: this sample is the end pressure
        baseline_nxt = pressure;
        rep_nxt      = 1'b1;
        mode_nxt     = tpvd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= tpvd_pkg::PH_IDLE;
      baseline_r   <= '0;
      start_pres_r <= '0;
      pour_t0_r    <= '0;
      settle_t0_r  <= '0;
    end else if (in_accept) begin
      mode_r       <= mode_nxt;
      baseline_r   <= baseline_nxt;
      start_pres_r <= start_pres_nxt;
      pour_t0_r    <= pour_t0_nxt;
      settle_t0_r  <= settle_t0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: phase, report flag, pressure drop, duration
  // --------------------------------------------------------------------------
  tpvd_pkg::phase_t                    s1_phase_r;
  logic                                s1_rep_r;
  logic signed [tpvd_pkg::DIFF_W-1:0]  s1_diff_r;
  logic [tpvd_pkg::TIME_W-1:0]         s1_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_rep_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_tvalid;
      s1_rep_r <= in_tvalid && rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_phase_r <= mode_nxt;
      s1_diff_r  <= $signed({1'b0, start_pres_r}) - $signed({1'b0, pressure});
      s1_dur_r   <= now_ms - pour_t0_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: volume = round(diff * gain / 256), saturated; minimum check
  // --------------------------------------------------------------------------
  logic signed [tpvd_pkg::PROD_W-1:0]  prod;
  logic signed [tpvd_pkg::RND_W-1:0]   rnd;
  logic signed [tpvd_pkg::VWIDE_W-1:0] vwide;
  logic signed [tpvd_pkg::VOL_W-1:0]   vol_sat;
  logic                                rec;

  assign prod  = $signed({{(tpvd_pkg::PROD_W-tpvd_pkg::DIFF_W){s1_diff_r[tpvd_pkg::DIFF_W-1]}},
                          s1_diff_r})
               * $signed({{(tpvd_pkg::PROD_W-tpvd_pkg::CFG16_W){1'b0}}, volume_gain_r});
  // floor((p + 128) / 256): ties round toward +infinity
  assign rnd   = $signed({prod[tpvd_pkg::PROD_W-1], prod}) + tpvd_pkg::RND_HALF;
  assign vwide = rnd[tpvd_pkg::RND_W-1:8];

  always_comb begin
    if (vwide > tpvd_pkg::VOL_MAX)      vol_sat = tpvd_pkg::VOL_MAX[tpvd_pkg::VOL_W-1:0];
    else if (vwide < tpvd_pkg::VOL_MIN) vol_sat = tpvd_pkg::VOL_MIN[tpvd_pkg::VOL_W-1:0];
    else                                vol_sat = vwide[tpvd_pkg::VOL_W-1:0];
  end

  assign rec = vwide >= $signed({10'd0, min_volume_r});

  logic [63:0] out_data_r;
  logic        out_rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_rep_r  <= s1_rep_r;
      out_data_r <= {5'd0,
                     s1_rep_r && rec,
                     s1_rep_r ? s1_dur_r : {tpvd_pkg::TIME_W{1'b0}},
                     s1_rep_r ? vol_sat  : {tpvd_pkg::VOL_W{1'b0}},
                     s1_phase_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rep_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a report always leaves the machine in idle
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == tpvd_pkg::PH_IDLE)
    else $error("report word with non-idle phase");

  // non-report words carry zero payload
  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[58:2] == 57'd0)
    else $error("non-report word carries payload");

  // a sample taken in reporting produces a report in stage 1
  a_rep_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && mode_r == tpvd_pkg::PH_REPORTING |=> s1_vld_r && s1_rep_r)
    else $error("reporting sample lost its report");

  // an empty first stage never back-pressures the source
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("ready low with empty stage");

endmodule
